>>> design/ktk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ktk_pkg;

	localparam int MAX_RANK = 64;
	localparam int DATA_W   = 32;
	localparam int RANK_W   = 7;
	localparam int IDX_W    = $clog2(MAX_RANK);
	localparam int CNT_W    = $clog2(MAX_RANK + 1);

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic clear;
		logic ins;
		logic rep;
		logic rd_parent;
		logic rd_left;
		logic rd_right;
		logic wr_cur;
		logic wr_up;
		logic wr_dn;
	} ktk_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic insert_ok;
		logic replace_ok;
		logic pos_zero;
		logic left_in;
		logic up_stop;
		logic dn_stop;
	} ktk_stat_t;

endpackage
`default_nettype wire

>>> design/ktk_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ktk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> design/ktk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ktk_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              cfg_wr,
	input  wire ktk_pkg::ktk_stat_t stat,
	output ktk_pkg::ktk_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_UP_RD  = 3'd2;
	localparam logic [2:0] S_UP_CMP = 3'd3;
	localparam logic [2:0] S_DN_RDL = 3'd4;
	localparam logic [2:0] S_DN_RDR = 3'd5;
	localparam logic [2:0] S_DN_CMP = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		done      = 1'b0;
		state_nxt = state_q;
		cmd.clear = cfg_wr;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.insert_ok) begin
					cmd.ins   = 1'b1;
					state_nxt = S_UP_RD;
				end else if (stat.replace_ok) begin
					cmd.rep   = 1'b1;
					state_nxt = S_DN_RDL;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_UP_RD: begin
				if (stat.pos_zero) begin
					cmd.wr_cur = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					cmd.rd_parent = 1'b1;
					state_nxt     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_stop) begin
					cmd.wr_cur = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					cmd.wr_up = 1'b1;
					state_nxt = S_UP_RD;
				end
			end
			S_DN_RDL: begin
				if (!stat.left_in) begin
					cmd.wr_cur = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					cmd.rd_left = 1'b1;
					state_nxt   = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				cmd.rd_right = 1'b1;
				state_nxt    = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (stat.dn_stop) begin
					cmd.wr_cur = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					cmd.wr_dn = 1'b1;
					state_nxt = S_DN_RDL;
				end
			end
			S_DONE: begin
				done      = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> design/ktk_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ktk_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ktk_pkg::ktk_cmd_t                  cmd,
	input  wire logic signed [ktk_pkg::DATA_W-1:0]  value,
	input  wire logic                               preload,
	input  wire logic        [ktk_pkg::RANK_W-1:0]  kth_rank,
	output ktk_pkg::ktk_stat_t                      stat,
	output logic signed      [ktk_pkg::DATA_W-1:0]  root,
	output logic                                    full,
	output logic                                    pre
);

	localparam int DW = ktk_pkg::DATA_W;
	localparam int IW = ktk_pkg::IDX_W;
	localparam int CW = ktk_pkg::CNT_W;

	logic        [ktk_pkg::RANK_W-1:0] k_q;
	logic        [CW-1:0]              fill_q;
	logic        [IW-1:0]              pos_q;
	logic signed [DW-1:0]              cur_q;
	logic signed [DW-1:0]              left_q;
	logic signed [DW-1:0]              root_q;
	logic                              pre_q;

	logic        [CW-1:0] eff_k;
	logic        [CW:0]   left_idx;
	logic        [CW:0]   right_idx;
	logic        [IW-1:0] parent_idx;
	logic                 right_in;
	logic signed [DW-1:0] rdata;
	logic signed [DW-1:0] min_lc;
	logic signed [DW-1:0] child;
	logic                 sel_left;
	logic                 sel_right;
	logic        [IW-1:0] lo_idx;
	logic                 we;
	logic        [IW-1:0] raddr;
	logic signed [DW-1:0] wdata;

	// clamp rank to 1 .. MAX_RANK
	always_comb begin
		if (k_q == '0) begin
			eff_k = CW'(1);
		end else if ({1'b0, k_q} > (ktk_pkg::RANK_W + 1)'(ktk_pkg::MAX_RANK)) begin
			eff_k = CW'(ktk_pkg::MAX_RANK);
		end else begin
			eff_k = CW'(k_q);
		end
	end

	assign left_idx   = (CW + 1)'({pos_q, 1'b1});
	assign right_idx  = left_idx + 1'b1;
	assign parent_idx = IW'((pos_q - 1'b1) >> 1);
	assign right_in   = right_idx < {1'b0, fill_q};

	// pick the smallest of hole value, left child and right child
	assign sel_left  = left_q < cur_q;
	assign min_lc    = sel_left ? left_q : cur_q;
	assign sel_right = right_in && (rdata < min_lc);
	assign child     = sel_right ? rdata : left_q;
	assign lo_idx    = sel_right ? right_idx[IW-1:0] : left_idx[IW-1:0];

	assign stat.insert_ok  = fill_q < eff_k;
	assign stat.replace_ok = cur_q > root_q;
	assign stat.pos_zero   = (pos_q == '0);
	assign stat.left_in    = left_idx < {1'b0, fill_q};
	assign stat.up_stop    = cur_q >= rdata;
	assign stat.dn_stop    = !sel_left && !sel_right;

	always_comb begin
		raddr = '0;
		if (cmd.rd_parent) begin
			raddr = parent_idx;
		end else if (cmd.rd_left) begin
			raddr = left_idx[IW-1:0];
		end else if (cmd.rd_right) begin
			raddr = right_idx[IW-1:0];
		end
	end

	assign we = cmd.wr_cur | cmd.wr_up | cmd.wr_dn;

	always_comb begin
		wdata = child;
		if (cmd.wr_cur) begin
			wdata = cur_q;
		end else if (cmd.wr_up) begin
			wdata = rdata;
		end
	end

	ktk_ram #(
		.WIDTH(DW),
		.DEPTH(ktk_pkg::MAX_RANK)
	) u_heap (
		.clk  (clk),
		.we   (we),
		.waddr(pos_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= ktk_pkg::RANK_W'(1);
			fill_q <= '0;
		end else begin
			if (cmd.clear) begin
				k_q    <= kth_rank;
				fill_q <= '0;
			end else if (cmd.ins) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cur_q <= value;
			pre_q <= preload;
		end
		if (cmd.ins) begin
			pos_q <= fill_q[IW-1:0];
		end else if (cmd.rep) begin
			pos_q <= '0;
		end else if (cmd.wr_up) begin
			pos_q <= parent_idx;
		end else if (cmd.wr_dn) begin
			pos_q <= lo_idx;
		end
		if (cmd.rd_right) begin
			left_q <= rdata;
		end
		// mirror of entry zero
		if (we && (pos_q == '0)) begin
			root_q <= wdata;
		end
	end

	assign root = root_q;
	assign full = fill_q >= eff_k;
	assign pre  = pre_q;

endmodule
`default_nettype wire

>>> design/kth_largest_stream_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// sift-up reads the parent and then compares at each level climbed, sift-down reads the
// left child, then the right child, and then compares at each level descended (two child reads
// on one ram read port); the result strobe follows the end of the sift
// items are taken one at a time; busy high until the work is done
// reset: heap empty, rank 1, no result pending; heap ram contents are not cleared
// the receiver cannot stall: result_valid is a one-cycle strobe
module kth_largest_stream_tracker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// item command
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic signed [ktk_pkg::DATA_W-1:0]  value,
	input  wire logic                               preload,
	// rank register write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic        [ktk_pkg::RANK_W-1:0]  kth_rank,
	// result
	output logic                                    result_valid,
	output logic signed      [ktk_pkg::DATA_W-1:0]  kth_value,
	output logic                                    rank_reached
);

	ktk_pkg::ktk_cmd_t  cmd;
	ktk_pkg::ktk_stat_t stat;

	logic                               done;
	logic                               cfg_wr;
	logic signed [ktk_pkg::DATA_W-1:0]  root;
	logic                               full;
	logic                               pre;

	// rank writes are taken only between items; a write also empties the heap
	assign cfg_ready = !busy;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// sequencer: decide, sift up or sift down, then report
	ktk_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cfg_wr(cfg_wr),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// heap ram, fill count, rank register and the hole-based sift datapath
	ktk_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.value   (value),
		.preload (preload),
		.kth_rank(kth_rank),
		.stat    (stat),
		.root    (root),
		.full    (full),
		.pre     (pre)
	);

	// result strobe; preload items finish silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= done && !pre;
		end
	end

	// result payload, taken once the heap has settled
	always_ff @(posedge clk) begin
		if (done) begin
			kth_value    <= root;
			rank_reached <= full;
		end
	end

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;

	typedef enum logic [1:0] {
		OP_ITEM,
		OP_RANK,
		OP_DRAIN
	} op_kind_t;

	// one entry of the stimulus plan
	typedef struct {
		op_kind_t kind;
		logic signed [ktk_pkg::DATA_W-1:0] value;
		logic preload;
		logic [ktk_pkg::RANK_W-1:0] rank;
		logic gapless;
	} plan_op_t;

	// one reported root
	typedef struct packed {
		logic signed [ktk_pkg::DATA_W-1:0] kth_value;
		logic rank_reached;
	} root_report_t;

	localparam int SETTLE_CYCLES = 30;	// longest sift plus margin
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1800;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [ktk_pkg::DATA_W-1:0] value = '0;
	logic preload = 1'b0;
	logic cfg_valid = 1'b0;
	logic [ktk_pkg::RANK_W-1:0] kth_rank = '0;
	logic busy;
	logic cfg_ready;
	logic result_valid;
	logic signed [ktk_pkg::DATA_W-1:0] kth_value;
	logic rank_reached;

	plan_op_t pending_ops[$];
	root_report_t expected_roots[$];
	int errors = 0;
	int items_planned = 0;
	int quiet_cycles = 0;
	logic took_item = 1'b0;
	logic took_cfg = 1'b0;

	// shadow copy of the heap and rank register
	logic signed [ktk_pkg::DATA_W-1:0] heap_mem[ktk_pkg::MAX_RANK];
	int fill_cnt = 0;
	logic [ktk_pkg::RANK_W-1:0] rank_reg = 7'd1;

	kth_largest_stream_tracker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.preload(preload),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.kth_rank(kth_rank),
		.result_valid(result_valid),
		.kth_value(kth_value),
		.rank_reached(rank_reached)
	);

	always #6 clk = ~clk;

	// rank register clamped to 1 .. MAX_RANK
	function automatic int rank_in_force();
		if (rank_reg == 0)
			return 1;
		if (rank_reg > ktk_pkg::MAX_RANK)
			return ktk_pkg::MAX_RANK;
		return int'(rank_reg);
	endfunction

	// min-heap update for one incoming value
	function automatic void heap_track(input logic signed [ktk_pkg::DATA_W-1:0] v);
		int k;
		int pos;
		int par;
		int lo;
		int l;
		int r;
		logic done;
		logic signed [ktk_pkg::DATA_W-1:0] t;
		k = rank_in_force();
		if (fill_cnt < k) begin
			// append and sift up
			heap_mem[fill_cnt] = v;
			pos = fill_cnt;
			fill_cnt++;
			done = 1'b0;
			while (pos > 0 && !done) begin
				par = (pos - 1) / 2;
				if (heap_mem[pos] >= heap_mem[par]) begin
					done = 1'b1;
				end else begin
					t = heap_mem[pos];
					heap_mem[pos] = heap_mem[par];
					heap_mem[par] = t;
					pos = par;
				end
			end
		end else if (v > heap_mem[0]) begin
			// replace root and sift down; equal to root is dropped
			heap_mem[0] = v;
			pos = 0;
			done = 1'b0;
			while (!done) begin
				lo = pos;
				l = 2 * pos + 1;
				r = l + 1;
				if (l < fill_cnt && heap_mem[l] < heap_mem[lo])
					lo = l;
				if (r < fill_cnt && heap_mem[r] < heap_mem[lo])
					lo = r;
				if (lo == pos) begin
					done = 1'b1;
				end else begin
					t = heap_mem[pos];
					heap_mem[pos] = heap_mem[lo];
					heap_mem[lo] = t;
					pos = lo;
				end
			end
		end
	endfunction

	task automatic add_item(input logic signed [ktk_pkg::DATA_W-1:0] v, input logic pre);
		plan_op_t op;
		op.kind = OP_ITEM;
		op.value = v;
		op.preload = pre;
		op.rank = '0;
		// one long window with back-to-back issue
		op.gapless = (items_planned >= 800 && items_planned < 1100);
		pending_ops.push_back(op);
		items_planned++;
	endtask

	task automatic add_rank(input logic [ktk_pkg::RANK_W-1:0] r);
		plan_op_t op;
		op.kind = OP_RANK;
		op.value = '0;
		op.preload = 1'b0;
		op.rank = r;
		op.gapless = 1'b0;
		pending_ops.push_back(op);
	endtask

	task automatic add_drain();
		plan_op_t op;
		op.kind = OP_DRAIN;
		op.value = '0;
		op.preload = 1'b0;
		op.rank = '0;
		op.gapless = 1'b0;
		pending_ops.push_back(op);
	endtask

	// mix of full range, duplicates around zero and the extremes
	function automatic logic signed [ktk_pkg::DATA_W-1:0] pick_value();
		int s;
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: begin
				s = $urandom_range(16);
				return s - 8;
			end
			7: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			8: begin
				s = $urandom_range(3);
				return $urandom_range(1) ? 32'sh7fffffff - s : 32'sh80000000 + s;
			end
			default: return $urandom_range(1000);
		endcase
	endfunction

	// driver: inputs change on the falling edge
	always @(negedge clk) begin : drive
		logic nxt_start;
		logic nxt_cfg;
		plan_op_t op;
		nxt_start = start;
		nxt_cfg = cfg_valid;
		if (took_item)
			nxt_start = 1'b0;
		if (took_cfg)
			nxt_cfg = 1'b0;
		if (arst_n && !nxt_start && !nxt_cfg && pending_ops.size() > 0) begin
			op = pending_ops[0];
			case (op.kind)
				OP_ITEM: begin
					if (op.gapless || $urandom_range(99) >= 29) begin
						void'(pending_ops.pop_front());
						nxt_start = 1'b1;
						value <= op.value;
						preload <= op.preload;
					end
				end
				OP_RANK: begin
					// rank write only once the block has gone quiet
					if (expected_roots.size() != 0 || busy) begin
						quiet_cycles = 0;
					end else if (quiet_cycles < SETTLE_CYCLES) begin
						quiet_cycles++;
					end else if ($urandom_range(99) >= 29) begin
						quiet_cycles = 0;
						void'(pending_ops.pop_front());
						nxt_cfg = 1'b1;
						kth_rank <= op.rank;
					end
				end
				default: begin
					// hold off until every pending root has come back
					if (expected_roots.size() == 0)
						void'(pending_ops.pop_front());
				end
			endcase
		end
		start <= nxt_start;
		cfg_valid <= nxt_cfg;
	end

	// monitor: sample on the rising edge, check roots, advance the shadow heap
	always @(posedge clk) begin : watch
		root_report_t want;
		if (!arst_n) begin
			took_item <= 1'b0;
			took_cfg <= 1'b0;
		end else begin
			took_item <= start && !busy;
			took_cfg <= cfg_valid && cfg_ready;
			if (result_valid) begin
				if (expected_roots.size() == 0) begin
					errors++;
					$display("%0t: unexpected root, expected none, actual %0d / %0b",
						$time, kth_value, rank_reached);
				end else begin
					want = expected_roots.pop_front();
					if (kth_value !== want.kth_value) begin
						errors++;
						$display("%0t: kth_value mismatch, expected %0d, actual %0d",
							$time, want.kth_value, kth_value);
					end
					if (rank_reached !== want.rank_reached) begin
						errors++;
						$display("%0t: rank_reached mismatch, expected %0b, actual %0b",
							$time, want.rank_reached, rank_reached);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				// any rank write empties the heap
				rank_reg = kth_rank;
				fill_cnt = 0;
			end
			if (start && !busy) begin
				heap_track(value);
				if (!preload) begin
					want.kth_value = heap_mem[0];
					want.rank_reached = (fill_cnt >= rank_in_force());
					expected_roots.push_back(want);
				end
			end
		end
	end

	initial begin : stimulus
		int r;
		int eff;
		int n_pre;
		int n_run;
		int phase;
		int rand_start;
		logic [ktk_pkg::RANK_W-1:0] fixed_ranks[7];
		fixed_ranks = '{7'd127, 7'd64, 7'd2, 7'd1, 7'd0, 7'd65, 7'd33};

		// directed: rank 1, extremes, equal to root dropped
		add_rank(7'd1);
		add_item(32'sh80000000, 1'b0);
		add_item(32'sh7fffffff, 1'b0);
		add_item(32'sh7fffffff, 1'b0);
		add_item(32'sh00000000, 1'b0);
		// rank zero acts as one
		add_rank(7'd0);
		add_item(32'sd5, 1'b1);
		add_item(-32'sd1, 1'b0);
		add_item(32'sd6, 1'b0);
		// small heap with preload, sift both ways
		add_rank(7'd3);
		add_item(32'sd10, 1'b1);
		add_item(-32'sd3, 1'b1);
		add_item(32'sd7, 1'b0);
		add_item(32'sd7, 1'b0);
		add_item(-32'sd3, 1'b0);
		add_item(32'sh80000000, 1'b0);
		add_item(32'sh7fffffff, 1'b0);
		add_item(32'sd8, 1'b0);
		add_drain();
		// rank above capacity clamps
		add_rank(7'd127);
		add_item(32'sh55555555, 1'b1);
		add_item(32'shaaaaaaaa, 1'b0);
		add_item(-32'sd1, 1'b0);
		add_item(32'sd0, 1'b0);

		// random phases: preload burst then a stream of queries
		rand_start = items_planned;
		phase = 0;
		while (items_planned - rand_start < RANDOM_ITEMS) begin
			if (phase < 7)
				r = fixed_ranks[phase];
			else if ($urandom_range(1))
				r = $urandom_range(1, ktk_pkg::MAX_RANK);
			else
				r = $urandom_range(0, 127);
			add_rank(r[ktk_pkg::RANK_W-1:0]);
			eff = (r == 0) ? 1 : ((r > ktk_pkg::MAX_RANK) ? ktk_pkg::MAX_RANK : r);
			n_pre = $urandom_range(eff + 4);
			for (int i = 0; i < n_pre; i++)
				add_item(pick_value(), 1'b1);
			n_run = $urandom_range(40, 200);
			for (int i = 0; i < n_run; i++) begin
				add_item(pick_value(), $urandom_range(9) == 0);
				if ($urandom_range(199) == 0)
					add_drain();
			end
			phase++;
		end

		// reset
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for the plan to empty and every root to arrive
		while (pending_ops.size() != 0 || start || cfg_valid || expected_roots.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0 && expected_roots.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
